FILE: src/dahs_pkg.sv
`timescale 1ns / 1ps

package dahs_pkg;

  // Default parameter values
  localparam int unsigned PosWidthDefault = 32;
  localparam int unsigned GainFracDefault = 8;

  // Fixed field widths
  localparam int unsigned PortW   = 32;          // position and target ports
  localparam int unsigned DutyW   = 16;          // Q1.15 duty
  localparam int unsigned GainW   = 16;          // Q8.8 gain
  localparam int unsigned LimW    = 31;          // unsigned limits and tolerances
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ZW      = PortW + 1;   // zeroed position
  localparam int unsigned SkewW   = PortW + 2;   // left minus right
  localparam int unsigned ErrW    = PortW + 2;   // |target - zeroed position|

  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdHome   = 2'd1,
    CmdTarget = 2'd2,
    CmdAbort  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DriveNone     = 2'd0,
    DriveDuty     = 2'd1,
    DriveSetpoint = 2'd2
  } drive_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSyncGain      = 3'd0,
    RegMaxCorrection = 3'd1,
    RegSkewDeadband  = 3'd2,
    RegSkewFault     = 3'd3,
    RegTolerance     = 3'd4,
    RegMinHeight     = 3'd5,
    RegMaxHeight     = 3'd6,
    RegHomeDuty      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0]        sync_gain;
    logic [LimW-1:0]         max_correction;
    logic [LimW-1:0]         skew_deadband;
    logic [LimW-1:0]         skew_fault_limit;
    logic [LimW-1:0]         tolerance;
    logic signed [PortW-1:0] min_height;
    logic signed [PortW-1:0] max_height;
    logic signed [DutyW-1:0] home_duty;
  } cfg_t;

  // Per-stage load enables of the result pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Request-level control handed to each lane
  typedef struct packed {
    logic accept;
    logic homing_tick;
  } lane_ctl_t;

endpackage

FILE: src/dahs_lane.sv
`timescale 1ns / 1ps

module dahs_lane
  import dahs_pkg::*;
#(
  parameter int unsigned PosWidth = PosWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  pipe_en_t                en_i,
  input  logic                    homed_i,
  input  logic signed [PortW-1:0] raw_i,
  input  logic                    switch_i,
  input  logic signed [DutyW-1:0] home_duty_i,
  input  logic signed [PortW-1:0] target_s1_i,
  input  logic signed [PortW-1:0] target_s4_i,
  input  drive_kind_e             kind_s4_i,
  input  logic signed [PortW-1:0] adj_s4_i,
  output logic                    homed_o,
  output logic signed [PortW-1:0] offset_o,
  output logic signed [ZW-1:0]    z_s1_o,
  output logic [ErrW-1:0]         err_s2_o,
  output logic signed [PortW-1:0] value_o
);

  localparam int unsigned SatW = (PosWidth > PortW + 1) ? PosWidth : PortW + 1;
  localparam logic signed [SatW-1:0] PosHi = SatW'({(PosWidth - 1){1'b1}});
  localparam logic signed [SatW-1:0] PosLo = ~PosHi;

  logic signed [PortW-1:0] offset_q, offset_d;
  logic signed [DutyW-1:0] duty_d;
  logic signed [ZW-1:0]    z_d, z_s1_q;
  logic signed [DutyW-1:0] duty_s1_q, duty_s2_q, duty_s3_q, duty_s4_q;
  logic signed [ErrW-1:0]  diff_tz, diff_zt;
  logic [ErrW-1:0]         err_s2_q;
  logic signed [PortW:0]   setp_sum;
  logic signed [SatW-1:0]  setp_ext, setp_sat;
  logic signed [PortW-1:0] value_d, value_q;

  // Seek the bottom switch and latch the zero offset when it closes
  always_comb begin
    homed_o  = homed_i;
    offset_d = offset_q;
    duty_d   = '0;
    if (ctl_i.homing_tick && !homed_i) begin
      if (switch_i) begin
        homed_o  = 1'b1;
        offset_d = raw_i;
      end else begin
        duty_d = home_duty_i;
      end
    end
  end

  assign offset_o = offset_d;
  assign z_d      = {raw_i[PortW-1], raw_i} - {offset_d[PortW-1], offset_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (ctl_i.accept) begin
      offset_q <= offset_d;
    end
  end

  // Stage 1: zeroed position
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      z_s1_q    <= z_d;
      duty_s1_q <= duty_d;
    end
  end

  // Stage 2: absolute error against the target
  assign diff_tz = {{2{target_s1_i[PortW-1]}}, target_s1_i} - {z_s1_q[ZW-1], z_s1_q};
  assign diff_zt = {z_s1_q[ZW-1], z_s1_q} - {{2{target_s1_i[PortW-1]}}, target_s1_i};

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      err_s2_q  <= diff_tz[ErrW-1] ? diff_zt : diff_tz;
      duty_s2_q <= duty_s1_q;
    end
  end

  // Stages 3 and 4: hold the duty alongside the correction path
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      duty_s3_q <= duty_s2_q;
    end
    if (en_i.s4) begin
      duty_s4_q <= duty_s3_q;
    end
  end

  // Stage 5: saturated corrected setpoint, duty, or zero
  assign setp_sum = {target_s4_i[PortW-1], target_s4_i} + {adj_s4_i[PortW-1], adj_s4_i};
  assign setp_ext = SatW'(setp_sum);

  always_comb begin
    if (setp_ext > PosHi) begin
      setp_sat = PosHi;
    end else if (setp_ext < PosLo) begin
      setp_sat = PosLo;
    end else begin
      setp_sat = setp_ext;
    end
    case (kind_s4_i)
      DriveDuty:     value_d = PortW'(duty_s4_q);
      DriveSetpoint: value_d = setp_sat[PortW-1:0];
      default:       value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      value_q <= value_d;
    end
  end

  assign z_s1_o   = z_s1_q;
  assign err_s2_o = err_s2_q;
  assign value_o  = value_q;

endmodule

FILE: src/dahs_merge.sv
`timescale 1ns / 1ps

module dahs_merge
  import dahs_pkg::*;
#(
  parameter int unsigned PosWidth = PosWidthDefault,
  parameter int unsigned GainFrac = GainFracDefault
) (
  input  logic                    clk_i,
  input  pipe_en_t                en_i,
  input  cfg_t                    cfg_i,
  input  logic signed [PortW-1:0] raw_l_i,
  input  logic signed [PortW-1:0] raw_r_i,
  input  logic signed [PortW-1:0] offset_l_i,
  input  logic signed [PortW-1:0] offset_r_i,
  input  logic                    eval_ok_i,
  output logic                    fault_o,
  input  logic signed [ZW-1:0]    z_l_s1_i,
  input  logic signed [ZW-1:0]    z_r_s1_i,
  input  logic [ErrW-1:0]         err_l_s2_i,
  input  logic [ErrW-1:0]         err_r_s2_i,
  input  logic                    status_ok_s2_i,
  output logic signed [PortW-1:0] adj_l_s4_o,
  output logic signed [PortW-1:0] adj_r_s4_o,
  output logic                    at_setpoint_o,
  output logic signed [PortW-1:0] mean_o
);

  localparam int unsigned SatW  = (PosWidth > PortW + 1) ? PosWidth : PortW + 1;
  localparam int unsigned ProdW = GainW + LimW;
  localparam logic signed [SatW-1:0] PosHi = SatW'({(PosWidth - 1){1'b1}});
  localparam logic signed [SatW-1:0] PosLo = ~PosHi;

  logic signed [SkewW-1:0] raw_diff, off_diff, skew_d, lim_pos, lim_neg;
  logic signed [SkewW-1:0] skew_s1_q, skew_neg;
  logic [SkewW-1:0]        am_full;
  logic [LimW-1:0]         am_s2_q;
  logic                    neg_s2_q, neg_s3_q, db_s2_q, db_s3_q;
  logic signed [SkewW-1:0] pos_sum;
  logic signed [SatW-1:0]  mean_ext, mean_sat;
  logic signed [PortW-1:0] mean_s2_q, mean_s3_q, mean_s4_q, mean_q;
  logic [ProdW-1:0]        prod_s3_q, prod_shift;
  logic [ErrW:0]           err_sum, tol2;
  logic                    atsp_s3_q, atsp_s4_q, atsp_q;
  logic [LimW-1:0]         corr;
  logic signed [PortW-1:0] corr_s, adj_l_q, adj_r_q;

  // Skew from raw counts and offsets in parallel, then the fault window
  assign raw_diff = {{2{raw_l_i[PortW-1]}}, raw_l_i} - {{2{raw_r_i[PortW-1]}}, raw_r_i};
  assign off_diff = {{2{offset_l_i[PortW-1]}}, offset_l_i}
                  - {{2{offset_r_i[PortW-1]}}, offset_r_i};
  assign skew_d   = raw_diff - off_diff;
  assign lim_pos  = SkewW'(cfg_i.skew_fault_limit);
  assign lim_neg  = -lim_pos;
  assign fault_o  = eval_ok_i && ((skew_d > lim_pos) || (skew_d < lim_neg));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      skew_s1_q <= skew_d;
    end
  end

  // Stage 2: skew magnitude, deadband, floor mean of both positions
  assign skew_neg = -skew_s1_q;
  assign am_full  = skew_s1_q[SkewW-1] ? skew_neg : skew_s1_q;
  assign pos_sum  = {z_l_s1_i[ZW-1], z_l_s1_i} + {z_r_s1_i[ZW-1], z_r_s1_i};
  assign mean_ext = SatW'($signed(pos_sum[SkewW-1:1]));

  always_comb begin
    if (mean_ext > PosHi) begin
      mean_sat = PosHi;
    end else if (mean_ext < PosLo) begin
      mean_sat = PosLo;
    end else begin
      mean_sat = mean_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      am_s2_q   <= am_full[LimW-1:0];
      neg_s2_q  <= skew_s1_q[SkewW-1];
      db_s2_q   <= am_full < SkewW'(cfg_i.skew_deadband);
      mean_s2_q <= mean_sat[PortW-1:0];
    end
  end

  // Stage 3: gain product and setpoint window
  assign err_sum = (ErrW + 1)'(err_l_s2_i) + (ErrW + 1)'(err_r_s2_i);
  assign tol2    = (ErrW + 1)'({cfg_i.tolerance, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      prod_s3_q <= ProdW'(cfg_i.sync_gain) * ProdW'(am_s2_q);
      neg_s3_q  <= neg_s2_q;
      db_s3_q   <= db_s2_q;
      atsp_s3_q <= status_ok_s2_i && (err_sum <= tol2);
      mean_s3_q <= mean_s2_q;
    end
  end

  // Stage 4: scale, clamp, deadband, and split the correction by side
  assign prod_shift = prod_s3_q >> GainFrac;

  always_comb begin
    if (prod_shift > ProdW'(cfg_i.max_correction)) begin
      corr = cfg_i.max_correction;
    end else begin
      corr = prod_shift[LimW-1:0];
    end
    if (db_s3_q) begin
      corr = '0;
    end
  end

  assign corr_s = PortW'(corr);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      adj_l_q   <= neg_s3_q ? corr_s : -corr_s;
      adj_r_q   <= neg_s3_q ? -corr_s : corr_s;
      atsp_s4_q <= atsp_s3_q;
      mean_s4_q <= mean_s3_q;
    end
  end

  // Stage 5: status into the output register
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      atsp_q <= atsp_s4_q;
      mean_q <= mean_s4_q;
    end
  end

  assign adj_l_s4_o    = adj_l_q;
  assign adj_r_s4_o    = adj_r_q;
  assign at_setpoint_o = atsp_q;
  assign mean_o        = mean_q;

endmodule

FILE: src/dual_actuator_homing_sync_controller_core.sv
`timescale 1ns / 1ps

// Homing and skew-synchronization controller for two linked actuators.
// Request channel (in_valid_i/in_ready_o) carries a command with the target
// and both encoder counts and bottom switches; every request yields exactly
// one result on the result channel (out_valid_o/out_ready_i): drive kind and
// value per side, homing and fault status, at-setpoint and mean height.
// Registers are written on the cfg channel (cfg_valid_i/cfg_ready_o, always
// ready); the user must write them only while no request is in flight, which
// the block does not enforce. Throughput: one request per cycle unless a full
// pipeline is stalled. Homing flags, zero offsets, target and the skew fault
// decision are resolved in the accept cycle, so a request can follow its
// predecessor directly. Results pass five register stages (the first loaded
// at the accepting edge), set by the correction path (skew magnitude, gain
// multiply, clamp, saturated setpoint add) in the lane and merge pipeline.
// Each pipeline stage advances when it is empty or its successor moves, so
// requests are taken while a result waits; a full pipeline with the receiver
// stalled holds in_ready_o low. The result is held stable until taken.
// Reset clears state and offsets to zero and loads register reset values.

module dual_actuator_homing_sync_controller_core
  import dahs_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH     = PosWidthDefault,
  parameter int unsigned GAIN_FRACTION_BITS = GainFracDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [PortW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic signed [PortW-1:0] target_height_i,
  input  logic signed [PortW-1:0] left_raw_position_i,
  input  logic signed [PortW-1:0] right_raw_position_i,
  input  logic                    left_bottom_switch_i,
  input  logic                    right_bottom_switch_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              left_drive_kind_o,
  output logic signed [PortW-1:0] left_drive_value_o,
  output logic [1:0]              right_drive_kind_o,
  output logic signed [PortW-1:0] right_drive_value_o,
  output logic                    homing_busy_o,
  output logic                    left_is_homed_o,
  output logic                    right_is_homed_o,
  output logic                    has_target_out_o,
  output logic                    skew_fault_out_o,
  output logic                    at_setpoint_o,
  output logic signed [PortW-1:0] mean_height_o
);

  typedef struct packed {
    logic homing;
    logic left_homed;
    logic right_homed;
    logic target_valid;
    logic fault;
  } status_t;

  typedef struct packed {
    drive_kind_e             kind;
    status_t                 status;
    logic                    ok;
    logic signed [PortW-1:0] target;
  } stage_t;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e cfg_idx;

  logic                    homing_q, lh_q, rh_q, tv_q, fault_q;
  logic signed [PortW-1:0] tp_q;
  logic                    homing_d, lh_d, rh_d, tv_d, fault_d;
  logic signed [PortW-1:0] tp_d, tgt_clamped;
  logic                    pre_homing, pre_lh, pre_rh, pre_tv, pre_eval;
  logic signed [PortW-1:0] pre_tp;
  drive_kind_e             pre_kind, kind_d;
  logic                    eval_ok, skew_fault;

  cmd_e      cmd;
  logic      accept;
  lane_ctl_t lane_ctl;
  pipe_en_t  en;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;
  logic      v1_q, v2_q, v3_q, v4_q, v5_q;
  stage_t    st1_d, st1_q, st2_q, st3_q, st4_q, st5_q;

  logic                    l_homed_lane, r_homed_lane;
  logic signed [PortW-1:0] l_offset, r_offset;
  logic signed [ZW-1:0]    zl_s1, zr_s1;
  logic [ErrW-1:0]         errl_s2, errr_s2;
  logic signed [PortW-1:0] adjl_s4, adjr_s4;

  // Configuration write decode
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_reg_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    unique case (cfg_idx)
      RegSyncGain:      cfg_d.sync_gain        = cfg_data_i[GainW-1:0];
      RegMaxCorrection: cfg_d.max_correction   = cfg_data_i[LimW-1:0];
      RegSkewDeadband:  cfg_d.skew_deadband    = cfg_data_i[LimW-1:0];
      RegSkewFault:     cfg_d.skew_fault_limit = cfg_data_i[LimW-1:0];
      RegTolerance:     cfg_d.tolerance        = cfg_data_i[LimW-1:0];
      RegMinHeight:     cfg_d.min_height       = cfg_data_i;
      RegMaxHeight:     cfg_d.max_height       = cfg_data_i;
      RegHomeDuty:      cfg_d.home_duty        = cfg_data_i[DutyW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gain        <= '0;
      cfg_q.max_correction   <= '0;
      cfg_q.skew_deadband    <= '0;
      cfg_q.skew_fault_limit <= '1;
      cfg_q.tolerance        <= '0;
      cfg_q.min_height       <= '0;
      cfg_q.max_height       <= {1'b0, {(PortW - 1){1'b1}}};
      cfg_q.home_duty        <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline handshake: a stage loads when empty or when its successor moves
  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && rdy1;
  assign en         = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

  assign cmd                  = cmd_e'(cmd_i);
  assign lane_ctl.accept      = accept;
  assign lane_ctl.homing_tick = (cmd == CmdTick) && homing_q;

  // Clamp the requested target to the soft limits, upper limit winning
  always_comb begin
    if (target_height_i < cfg_q.min_height) begin
      tgt_clamped = (cfg_q.min_height > cfg_q.max_height) ? cfg_q.max_height
                                                           : cfg_q.min_height;
    end else if (target_height_i > cfg_q.max_height) begin
      tgt_clamped = cfg_q.max_height;
    end else begin
      tgt_clamped = target_height_i;
    end
  end

  // Decode the command into the next state before the skew check
  always_comb begin
    pre_homing = homing_q;
    pre_lh     = l_homed_lane;
    pre_rh     = r_homed_lane;
    pre_tv     = tv_q;
    pre_tp     = tp_q;
    pre_kind   = DriveNone;
    pre_eval   = 1'b0;
    unique case (cmd)
      CmdHome: begin
        pre_homing = 1'b1;
        pre_lh     = 1'b0;
        pre_rh     = 1'b0;
        pre_tv     = 1'b0;
      end
      CmdTarget: begin
        pre_tp = tgt_clamped;
        pre_tv = 1'b1;
      end
      CmdAbort: begin
        if (!(lh_q && rh_q)) begin
          pre_kind   = DriveDuty;
          pre_homing = 1'b0;
        end
      end
      CmdTick: begin
        if (homing_q) begin
          pre_kind = DriveDuty;
          if (l_homed_lane && r_homed_lane) begin
            pre_homing = 1'b0;
            pre_tp     = '0;
            pre_tv     = 1'b1;
            pre_eval   = 1'b1;
          end
        end else begin
          pre_eval = 1'b1;
        end
      end
    endcase
  end

  assign eval_ok = pre_eval && pre_lh && pre_rh && pre_tv;

  // Apply the skew fault or switch both sides to setpoints
  always_comb begin
    homing_d = pre_homing;
    lh_d     = pre_lh;
    rh_d     = pre_rh;
    tv_d     = pre_tv;
    tp_d     = pre_tp;
    fault_d  = fault_q;
    kind_d   = pre_kind;
    if (skew_fault) begin
      kind_d  = DriveDuty;
      lh_d    = 1'b0;
      rh_d    = 1'b0;
      tv_d    = 1'b0;
      fault_d = 1'b1;
    end else if (eval_ok) begin
      kind_d  = DriveSetpoint;
      fault_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      homing_q <= 1'b0;
      lh_q     <= 1'b0;
      rh_q     <= 1'b0;
      tv_q     <= 1'b0;
      tp_q     <= '0;
      fault_q  <= 1'b0;
    end else if (accept) begin
      homing_q <= homing_d;
      lh_q     <= lh_d;
      rh_q     <= rh_d;
      tv_q     <= tv_d;
      tp_q     <= tp_d;
      fault_q  <= fault_d;
    end
  end

  assign st1_d.kind   = kind_d;
  assign st1_d.status = '{homing: homing_d, left_homed: lh_d, right_homed: rh_d,
                          target_valid: tv_d, fault: fault_d};
  assign st1_d.ok     = lh_d && rh_d && tv_d;
  assign st1_d.target = tp_d;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Advance request payload
  always_ff @(posedge clk_i) begin
    if (rdy1) st1_q <= st1_d;
    if (rdy2) st2_q <= st1_q;
    if (rdy3) st3_q <= st2_q;
    if (rdy4) st4_q <= st3_q;
    if (rdy5) st5_q <= st4_q;
  end

  dahs_lane #(
    .PosWidth(POSITION_WIDTH)
  ) u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .en_i       (en),
    .homed_i    (lh_q),
    .raw_i      (left_raw_position_i),
    .switch_i   (left_bottom_switch_i),
    .home_duty_i(cfg_q.home_duty),
    .target_s1_i(st1_q.target),
    .target_s4_i(st4_q.target),
    .kind_s4_i  (st4_q.kind),
    .adj_s4_i   (adjl_s4),
    .homed_o    (l_homed_lane),
    .offset_o   (l_offset),
    .z_s1_o     (zl_s1),
    .err_s2_o   (errl_s2),
    .value_o    (left_drive_value_o)
  );

  dahs_lane #(
    .PosWidth(POSITION_WIDTH)
  ) u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .en_i       (en),
    .homed_i    (rh_q),
    .raw_i      (right_raw_position_i),
    .switch_i   (right_bottom_switch_i),
    .home_duty_i(cfg_q.home_duty),
    .target_s1_i(st1_q.target),
    .target_s4_i(st4_q.target),
    .kind_s4_i  (st4_q.kind),
    .adj_s4_i   (adjr_s4),
    .homed_o    (r_homed_lane),
    .offset_o   (r_offset),
    .z_s1_o     (zr_s1),
    .err_s2_o   (errr_s2),
    .value_o    (right_drive_value_o)
  );

  dahs_merge #(
    .PosWidth(POSITION_WIDTH),
    .GainFrac(GAIN_FRACTION_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .en_i          (en),
    .cfg_i         (cfg_q),
    .raw_l_i       (left_raw_position_i),
    .raw_r_i       (right_raw_position_i),
    .offset_l_i    (l_offset),
    .offset_r_i    (r_offset),
    .eval_ok_i     (eval_ok),
    .fault_o       (skew_fault),
    .z_l_s1_i      (zl_s1),
    .z_r_s1_i      (zr_s1),
    .err_l_s2_i    (errl_s2),
    .err_r_s2_i    (errr_s2),
    .status_ok_s2_i(st2_q.ok),
    .adj_l_s4_o    (adjl_s4),
    .adj_r_s4_o    (adjr_s4),
    .at_setpoint_o (at_setpoint_o),
    .mean_o        (mean_height_o)
  );

  // Drive the result ports from the output stage
  assign out_valid_o        = v5_q;
  assign left_drive_kind_o  = st5_q.kind;
  assign right_drive_kind_o = st5_q.kind;
  assign homing_busy_o      = st5_q.status.homing;
  assign left_is_homed_o    = st5_q.status.left_homed;
  assign right_is_homed_o   = st5_q.status.right_homed;
  assign has_target_out_o   = st5_q.status.target_valid;
  assign skew_fault_out_o   = st5_q.status.fault;

  // Homing never runs with both sides already homed
  a_homing_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    homing_q |-> !(lh_q && rh_q))
    else $error("homing active with both sides homed");

  // A new skew fault leaves both sides unhomed and no target
  a_fault_drops_homing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fault_q) |-> (!lh_q && !rh_q && !tv_q))
    else $error("skew fault kept homed state");

  // Setpoints are only issued while homed with a target
  a_setpoint_homed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && (st5_q.kind == DriveSetpoint)) |->
      (st5_q.status.left_homed && st5_q.status.right_homed &&
       st5_q.status.target_valid && !st5_q.status.fault))
    else $error("setpoint issued without homed target");

  // Hold a stalled result unchanged until it is taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(st5_q) && $stable(left_drive_value_o) &&
       $stable(right_drive_value_o) && $stable(at_setpoint_o) &&
       $stable(mean_height_o)))
    else $error("result changed while stalled");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dahs_pkg::*;

  localparam int     StallLimit = 4000;
  localparam longint PosHi      = 64'sd2147483647;
  localparam longint PosLo      = -PosHi - 1;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] target;
    logic signed [31:0] lraw;
    logic signed [31:0] rraw;
    logic               lsw;
    logic               rsw;
  } req_t;

  typedef struct {
    drive_kind_e        lkind;
    logic signed [31:0] lval;
    drive_kind_e        rkind;
    logic signed [31:0] rval;
    logic               busy;
    logic               lhomed;
    logic               rhomed;
    logic               armed;
    logic               fault;
    logic               atsp;
    logic signed [31:0] mean;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request channel
  logic in_valid = 1'b0;
  req_t drv_req = '{CmdTick, '0, '0, '0, 1'b0, 1'b0};
  logic in_ready_o;

  // Register write channel
  logic        cfg_valid = 1'b0;
  cfg_reg_e    cfg_index = RegSyncGain;
  logic [31:0] cfg_data = '0;
  logic        cfg_ready_o;

  // Result channel
  logic               out_ready = 1'b0;
  logic               out_valid_o;
  logic [1:0]         left_drive_kind_o, right_drive_kind_o;
  logic signed [31:0] left_drive_value_o, right_drive_value_o, mean_height_o;
  logic               homing_busy_o, left_is_homed_o, right_is_homed_o;
  logic               has_target_out_o, skew_fault_out_o, at_setpoint_o;

  // Register copy used for prediction
  logic [15:0]        cfg_gain = '0;
  logic [30:0]        cfg_max_corr = '0;
  logic [30:0]        cfg_deadband = '0;
  logic [30:0]        cfg_fault = 31'h7FFF_FFFF;
  logic [30:0]        cfg_tol = '0;
  logic signed [31:0] cfg_min = '0;
  logic signed [31:0] cfg_max = 32'sh7FFF_FFFF;
  logic signed [15:0] cfg_duty = '0;

  // Controller state copy used for prediction
  logic   homing_on = 1'b0;
  logic   left_homed = 1'b0;
  logic   right_homed = 1'b0;
  logic   target_armed = 1'b0;
  logic   fault_flag = 1'b0;
  longint target_pos = 0;
  longint left_off = 0;
  longint right_off = 0;

  req_t    pending_reqs[$];
  status_t expected_status[$];
  status_t oldest_status;
  int      issued = 0;
  int      results_seen = 0;
  int      fail_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      jitter_span = 16;

  dual_actuator_homing_sync_controller_core u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .cmd_i                (drv_req.cmd),
    .target_height_i      (drv_req.target),
    .left_raw_position_i  (drv_req.lraw),
    .right_raw_position_i (drv_req.rraw),
    .left_bottom_switch_i (drv_req.lsw),
    .right_bottom_switch_i(drv_req.rsw),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .left_drive_kind_o    (left_drive_kind_o),
    .left_drive_value_o   (left_drive_value_o),
    .right_drive_kind_o   (right_drive_kind_o),
    .right_drive_value_o  (right_drive_value_o),
    .homing_busy_o        (homing_busy_o),
    .left_is_homed_o      (left_is_homed_o),
    .right_is_homed_o     (right_is_homed_o),
    .has_target_out_o     (has_target_out_o),
    .skew_fault_out_o     (skew_fault_out_o),
    .at_setpoint_o        (at_setpoint_o),
    .mean_height_o        (mean_height_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sat_pos(longint v);
    if (v > PosHi) return 32'sh7FFF_FFFF;
    if (v < PosLo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Advance the controller copy by one request and return its status
  function automatic status_t run_controller_step(req_t r);
    status_t o;
    logic    eval;
    longint  t, zl, zr, skew, mag, corr, cr, err;
    o.lkind = DriveNone;
    o.rkind = DriveNone;
    o.lval  = '0;
    o.rval  = '0;
    eval    = 1'b0;
    case (r.cmd)
      CmdHome: begin
        homing_on    = 1'b1;
        left_homed   = 1'b0;
        right_homed  = 1'b0;
        target_armed = 1'b0;
      end
      CmdTarget: begin
        // clamp to the lower limit first, then the upper one
        t = r.target;
        if (t < cfg_min) t = cfg_min;
        if (t > cfg_max) t = cfg_max;
        target_pos   = t;
        target_armed = 1'b1;
      end
      CmdAbort: begin
        if (!(left_homed && right_homed)) begin
          o.lkind   = DriveDuty;
          o.rkind   = DriveDuty;
          homing_on = 1'b0;
        end
      end
      default: begin
        if (homing_on) begin
          // seek each unhomed side down until its switch closes
          o.lkind = DriveDuty;
          o.rkind = DriveDuty;
          if (!left_homed) begin
            if (r.lsw) begin
              left_off   = r.lraw;
              left_homed = 1'b1;
            end else begin
              o.lval = cfg_duty;
            end
          end
          if (!right_homed) begin
            if (r.rsw) begin
              right_off   = r.rraw;
              right_homed = 1'b1;
            end else begin
              o.rval = cfg_duty;
            end
          end
          if (left_homed && right_homed) begin
            homing_on    = 1'b0;
            target_pos   = 0;
            target_armed = 1'b1;
            eval         = 1'b1;
          end
        end else begin
          eval = 1'b1;
        end
      end
    endcase

    zl = longint'(r.lraw) - left_off;
    zr = longint'(r.rraw) - right_off;

    // skew correction, deadband and fault
    if (eval && left_homed && right_homed && target_armed) begin
      skew = zl - zr;
      mag  = (skew < 0) ? -skew : skew;
      corr = (longint'(cfg_gain) * mag) >>> GainFracDefault;
      if (corr > longint'(cfg_max_corr)) corr = longint'(cfg_max_corr);
      if (mag < longint'(cfg_deadband)) corr = 0;
      if (mag > longint'(cfg_fault)) begin
        o.lkind      = DriveDuty;
        o.rkind      = DriveDuty;
        o.lval       = '0;
        o.rval       = '0;
        left_homed   = 1'b0;
        right_homed  = 1'b0;
        target_armed = 1'b0;
        fault_flag   = 1'b1;
      end else begin
        cr         = (skew < 0) ? -corr : corr;
        fault_flag = 1'b0;
        o.lkind    = DriveSetpoint;
        o.rkind    = DriveSetpoint;
        o.lval     = sat_pos(target_pos - cr);
        o.rval     = sat_pos(target_pos + cr);
      end
    end

    o.atsp = 1'b0;
    if (left_homed && right_homed && target_armed) begin
      t   = target_pos - zl;
      err = (t < 0) ? -t : t;
      t   = target_pos - zr;
      err += (t < 0) ? -t : t;
      o.atsp = (err <= 2 * longint'(cfg_tol));
    end

    o.mean   = sat_pos((zl + zr) >>> 1);
    o.busy   = homing_on;
    o.lhomed = left_homed;
    o.rhomed = right_homed;
    o.armed  = target_armed;
    o.fault  = fault_flag;
    return o;
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [31:0] d);
    case (idx)
      RegSyncGain:      cfg_gain = d[15:0];
      RegMaxCorrection: cfg_max_corr = d[30:0];
      RegSkewDeadband:  cfg_deadband = d[30:0];
      RegSkewFault:     cfg_fault = d[30:0];
      RegTolerance:     cfg_tol = d[30:0];
      RegMinHeight:     cfg_min = d;
      RegMaxHeight:     cfg_max = d;
      default:          cfg_duty = d[15:0];
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] gain, logic [31:0] max_corr, logic [31:0] deadband,
                           logic [31:0] fault, logic [31:0] tol, logic [31:0] lo,
                           logic [31:0] hi, logic [31:0] duty);
    write_reg(RegSyncGain, gain);
    write_reg(RegMaxCorrection, max_corr);
    write_reg(RegSkewDeadband, deadband);
    write_reg(RegSkewFault, fault);
    write_reg(RegTolerance, tol);
    write_reg(RegMinHeight, lo);
    write_reg(RegMaxHeight, hi);
    write_reg(RegHomeDuty, duty);
    jitter_span = int'(cfg_fault >> 1) + 16;
  endtask

  task automatic push_req(cmd_e c, logic [31:0] tgt, logic [31:0] l, logic [31:0] r,
                          logic ls, logic rs);
    pending_reqs.push_back('{c, tgt, l, r, ls, rs});
    issued++;
  endtask

  task automatic wait_drained();
    while (results_seen != issued) @(posedge clk);
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic noise_req();
    push_req(cmd_e'($urandom_range(3)), $urandom, $urandom, $urandom,
             $urandom_range(1), $urandom_range(1));
  endtask

  // Home both sides, then run ticks, targets and aborts around the homed zero
  task automatic homed_run(int ticks);
    int     lbase, rbase, pick;
    longint guess, lpos, rpos;
    logic   lclosed, rclosed;
    logic signed [31:0] t;
    lbase   = int'($urandom) >>> 2;
    rbase   = int'($urandom) >>> 2;
    lclosed = 1'b0;
    rclosed = 1'b0;
    guess   = 0;
    push_req(CmdHome, $urandom, $urandom, $urandom, $urandom_range(1), $urandom_range(1));
    while (!(lclosed && rclosed)) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        push_req(CmdTarget, $urandom, lbase, rbase, lclosed, rclosed);
      end else if (pick < 9) begin
        push_req(CmdAbort, $urandom, lbase, rbase, lclosed, rclosed);
      end else begin
        if ($urandom_range(99) < 35) lclosed = 1'b1;
        if ($urandom_range(99) < 35) rclosed = 1'b1;
        push_req(CmdTick, $urandom, lbase + jitter(4), rbase + jitter(4), lclosed, rclosed);
      end
    end
    repeat (ticks) begin
      if ($urandom_range(1)) begin
        lpos = lbase + guess + jitter(8);
        rpos = rbase + guess + jitter(8);
      end else begin
        lpos = lbase + guess + jitter(jitter_span);
        rpos = rbase + guess + jitter(jitter_span);
      end
      pick = $urandom_range(99);
      if (pick < 18) begin
        t = (pick < 4) ? $urandom : jitter(20000);
        push_req(CmdTarget, t, lpos, rpos, $urandom_range(1), $urandom_range(1));
        guess = t;
        if (guess < cfg_min) guess = cfg_min;
        if (guess > cfg_max) guess = cfg_max;
      end else if (pick < 21) begin
        push_req(CmdAbort, $urandom, lpos, rpos, $urandom_range(1), $urandom_range(1));
      end else begin
        push_req(CmdTick, $urandom, lpos, rpos, $urandom_range(1), $urandom_range(1));
      end
    end
  endtask

  task automatic random_config(logic wide);
    logic [31:0] lo, hi, swap;
    if (wide) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    end else begin
      lo = -$urandom_range(50000);
      hi = $urandom_range(50000);
      if ($urandom_range(4) == 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      write_all($urandom_range(65535), $urandom_range(5000), $urandom_range(64),
                $urandom_range(4000), $urandom_range(200), lo, hi, $urandom);
    end
  endtask

  // Request driver: present queued requests, predict each on acceptance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_status.push_back(run_controller_step(drv_req));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  // Result monitor: compare each result with the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          oldest_status = expected_status.pop_front();
          check_field("left_drive_kind", 32'(oldest_status.lkind), 32'(left_drive_kind_o));
          check_field("left_drive_value", oldest_status.lval, left_drive_value_o);
          check_field("right_drive_kind", 32'(oldest_status.rkind), 32'(right_drive_kind_o));
          check_field("right_drive_value", oldest_status.rval, right_drive_value_o);
          check_field("homing_busy", 32'(oldest_status.busy), 32'(homing_busy_o));
          check_field("left_is_homed", 32'(oldest_status.lhomed), 32'(left_is_homed_o));
          check_field("right_is_homed", 32'(oldest_status.rhomed), 32'(right_is_homed_o));
          check_field("has_target_out", 32'(oldest_status.armed), 32'(has_target_out_o));
          check_field("skew_fault_out", 32'(oldest_status.fault), 32'(skew_fault_out_o));
          check_field("at_setpoint", 32'(oldest_status.atsp), 32'(at_setpoint_o));
          check_field("mean_height", oldest_status.mean, mean_height_o);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop the run when no channel moves for too long
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int first;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 79;

    // Moderate settings: homing, abort, clamping, deadband, correction, fault
    write_all(32'h0180, 1000, 4, 5000, 10, -1000, 100000, 32'hC000);
    push_req(CmdTick, 0, 100, 200, 1'b0, 1'b0);
    push_req(CmdAbort, 0, 100, 200, 1'b0, 1'b0);
    push_req(CmdTarget, 32'h7FFF_FFFF, 0, 0, 1'b0, 1'b0);
    push_req(CmdHome, 0, 0, 0, 1'b0, 1'b0);
    push_req(CmdTick, 0, 500, 600, 1'b0, 1'b0);
    push_req(CmdTarget, 32'h8000_0000, 500, 600, 1'b0, 1'b0);
    push_req(CmdTick, 0, 500, 600, 1'b1, 1'b0);
    push_req(CmdAbort, 0, 500, 600, 1'b1, 1'b0);
    push_req(CmdHome, 0, 500, 600, 1'b0, 1'b0);
    push_req(CmdTick, 0, 1000, 2000, 1'b1, 1'b1);
    push_req(CmdTick, 0, 1002, 2000, 1'b0, 1'b0);
    push_req(CmdTick, 0, 1100, 2000, 1'b0, 1'b0);
    push_req(CmdTick, 0, 1000, 4000, 1'b0, 1'b0);
    push_req(CmdAbort, 0, 1000, 2000, 1'b0, 1'b0);
    push_req(CmdTarget, 500, 1500, 2500, 1'b0, 1'b0);
    push_req(CmdTick, 0, 10000, 2000, 1'b0, 1'b0);
    wait_drained();

    // Upper extremes: setpoint and mean saturation
    write_all(32'hFFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF);
    push_req(CmdHome, 0, 0, 0, 1'b0, 1'b0);
    push_req(CmdTick, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    push_req(CmdTarget, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_0000, 1'b0, 1'b0);
    push_req(CmdTick, 0, 32'h7FFF_FFFF, 32'h7FFF_0000, 1'b0, 1'b0);
    push_req(CmdTick, 0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    wait_drained();

    // Zero limits, lower limit above upper, most negative duty
    write_all(0, 0, 32'h7FFF_FFFF, 0, 0, 5, -5, 32'h8000);
    push_req(CmdHome, 0, 0, 0, 1'b0, 1'b0);
    push_req(CmdTick, 0, 0, 0, 1'b1, 1'b0);
    push_req(CmdTick, 0, 0, 0, 1'b0, 1'b1);
    push_req(CmdTarget, 77, 0, 0, 1'b0, 1'b0);
    push_req(CmdTick, 0, 1, 0, 1'b0, 1'b0);
    wait_drained();

    // Random phases, each under fresh register settings
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 31;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config(p == 5);
      first = issued;
      while (issued - first < 333) begin
        if ($urandom_range(99) < 75) begin
          homed_run($urandom_range(4, 16));
        end else begin
          repeat ($urandom_range(1, 6)) noise_req();
        end
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (20) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
